// ===== rtl/core/lpf_pkg.sv =====
// ----------------------------------------------------------------------------
// lpf_pkg
// Shared types and constants of the plaquette flip update core: grid size
// defaults, transaction field widths, function codes and payload structs.
// ----------------------------------------------------------------------------
package lpf_pkg;

	localparam int ROWS_DEF   = 6;
	localparam int COLS_DEF   = 4;
	localparam int COLORS_DEF = 3;

	localparam int NUM_LABELS = 3;

	localparam int FUNC_W  = 1;
	localparam int ROW_W   = 3;
	localparam int COL_W   = 2;
	localparam int COLOR_W = 2;
	localparam int STEP_W  = 2;
	localparam int LABEL_W = 3;

	localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_FLIP  = 1'b1;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [ROW_W-1:0]   cell_row;
		logic [COL_W-1:0]   cell_col;
		logic [COLOR_W-1:0] spin_color;
		logic [STEP_W-1:0]  color_step;
	} lpf_item_t;

	typedef struct packed {
		logic               was_flipped;
		logic [COLOR_W-1:0] cell_color;
		logic               grid_valid;
		logic [LABEL_W-1:0] vertical_label_0;
		logic [LABEL_W-1:0] vertical_label_1;
		logic [LABEL_W-1:0] vertical_label_2;
		logic [LABEL_W-1:0] horizontal_label_0;
		logic [LABEL_W-1:0] horizontal_label_1;
		logic [LABEL_W-1:0] horizontal_label_2;
	} lpf_result_t;

endpackage

// ===== rtl/core/lpf_if.sv =====
// ----------------------------------------------------------------------------
// lpf_if
// Valid/ready channels of the plaquette flip update core, one for the
// input transactions and one for the result transactions.
// ----------------------------------------------------------------------------
interface lpf_item_if;
	import lpf_pkg::*;

	logic      valid;
	logic      ready;
	lpf_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface lpf_result_if;
	import lpf_pkg::*;

	logic        valid;
	logic        ready;
	lpf_result_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/core/lattice_plaquette_flip_update_core.sv =====
// ----------------------------------------------------------------------------
// lattice_plaquette_flip_update_core
// Stages: input register, then result register. Throughput: one transaction
// per cycle unless the receiver stalls; the grid update, plaquette check and
// label counts form one combinational pass between input and result registers.
// Reset: asynchronous; clears the grid to color zero and empties both stages.
// Toroidal spin grid held in flops; write or plaquette flip per transaction.
// ----------------------------------------------------------------------------
module lattice_plaquette_flip_update_core #(
	parameter int ROWS   = lpf_pkg::ROWS_DEF,
	parameter int COLS   = lpf_pkg::COLS_DEF,
	parameter int COLORS = lpf_pkg::COLORS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	lpf_item_if.sink     items,
	lpf_result_if.source results
);
	import lpf_pkg::*;

	localparam int CELLS = ROWS * COLS;
	localparam int CW    = (COLORS > 2) ? $clog2(COLORS) : 1;
	localparam int RW    = $clog2(ROWS);
	localparam int CLW   = $clog2(COLS);
	localparam int VW    = $clog2(ROWS) + 3;
	localparam int HW    = $clog2(COLS) + 3;

	function automatic logic [CW-1:0] mod_colors(input logic [3:0] v);
		logic [CW-1:0] res;
		res = '0;
		for (int i = 0; i < 16; i++) begin
			if (v == 4'(i)) begin
				res = CW'(i % COLORS);
			end
		end
		return res;
	endfunction

	function automatic logic [RW-1:0] mod_rows(input logic [ROW_W-1:0] v);
		logic [RW-1:0] res;
		res = '0;
		for (int i = 0; i < (1 << ROW_W); i++) begin
			if (v == ROW_W'(i)) begin
				res = RW'(i % ROWS);
			end
		end
		return res;
	endfunction

	function automatic logic [CLW-1:0] mod_cols(input logic [COL_W-1:0] v);
		logic [CLW-1:0] res;
		res = '0;
		for (int i = 0; i < (1 << COL_W); i++) begin
			if (v == COL_W'(i)) begin
				res = CLW'(i % COLS);
			end
		end
		return res;
	endfunction

	logic [CW-1:0] grid_q [CELLS];
	logic [CW-1:0] grid_next [CELLS];

	lpf_item_t   item_s1;
	logic        valid_s1;
	lpf_result_t result_s2;
	logic        valid_s2;
	logic        advance;

	logic [RW-1:0]  row_sel;
	logic [CLW-1:0] col_sel;
	logic           flip_any;
	logic [CW-1:0]  cell_new;
	logic [CW-1:0]  cell_old;
	logic           plaq_ok;
	logic [LABEL_W-1:0] vlabel [NUM_LABELS];
	logic [LABEL_W-1:0] hlabel [NUM_LABELS];
	logic [3:0]     color_wide;

	assign advance     = valid_s1 && (!valid_s2 || results.ready);
	assign items.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			for (int i = 0; i < CELLS; i++) begin
				grid_q[i] <= '0;
			end
		end else begin
			if (items.ready) begin
				valid_s1 <= items.valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (results.ready) begin
				valid_s2 <= 1'b0;
			end
			for (int i = 0; i < CELLS; i++) begin
				grid_q[i] <= grid_next[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			item_s1 <= items.data;
		end
		if (advance) begin
			result_s2.was_flipped        <= flip_any;
			result_s2.cell_color         <= color_wide[COLOR_W-1:0];
			result_s2.grid_valid         <= plaq_ok;
			result_s2.vertical_label_0   <= vlabel[0];
			result_s2.vertical_label_1   <= vlabel[1];
			result_s2.vertical_label_2   <= vlabel[2];
			result_s2.horizontal_label_0 <= hlabel[0];
			result_s2.horizontal_label_1 <= hlabel[1];
			result_s2.horizontal_label_2 <= hlabel[2];
		end
	end

	assign results.valid = valid_s2;
	assign results.data  = result_s2;

	// cell update: every cell evaluates its own flip condition
	always_comb begin
		logic          sel;
		logic          cond;
		logic [CW-1:0] right_c;
		logic [CW-1:0] upd;
		row_sel  = mod_rows(item_s1.cell_row);
		col_sel  = mod_cols(item_s1.cell_col);
		flip_any = 1'b0;
		cell_new = '0;
		cell_old = '0;
		for (int r = 0; r < ROWS; r++) begin
			for (int c = 0; c < COLS; c++) begin
				sel     = (row_sel == RW'(r)) && (col_sel == CLW'(c));
				right_c = grid_q[r * COLS + ((c + 1) % COLS)];
				cond    = (grid_q[((r + 1) % ROWS) * COLS + c] == right_c) &&
					(grid_q[r * COLS + ((c + COLS - 1) % COLS)] == right_c) &&
					(grid_q[((r + ROWS - 1) % ROWS) * COLS + c] == right_c);
				if (item_s1.func == FUNC_FLIP) begin
					upd = cond ? mod_colors(4'(grid_q[r * COLS + c]) + 4'(item_s1.color_step))
						: grid_q[r * COLS + c];
				end else begin
					upd = mod_colors(4'(item_s1.spin_color));
				end
				if (sel && advance) begin
					grid_next[r * COLS + c] = upd;
				end else begin
					grid_next[r * COLS + c] = grid_q[r * COLS + c];
				end
				if (sel) begin
					cell_new = upd;
					cell_old = grid_q[r * COLS + c];
					flip_any = (item_s1.func == FUNC_FLIP) && (upd != grid_q[r * COLS + c]);
				end
			end
		end
		color_wide = 4'(cell_new);
	end

	// plaquette check and symmetry labels on the updated grid
	always_comb begin
		logic [CW-1:0]  ch;
		logic [ROWS-1:0] v_even [NUM_LABELS];
		logic [ROWS-1:0] v_odd  [NUM_LABELS];
		logic [COLS-1:0] h_even [NUM_LABELS];
		logic [COLS-1:0] h_odd  [NUM_LABELS];
		logic [VW-1:0]  vsum;
		logic [HW-1:0]  hsum;
		plaq_ok = 1'b1;
		for (int r = 0; r < ROWS; r++) begin
			for (int c = 0; c < COLS; c++) begin
				if (!((grid_next[r * COLS + c] ==
					grid_next[((r + ROWS - 1) % ROWS) * COLS + ((c + COLS - 1) % COLS)]) ||
					(grid_next[((r + ROWS - 1) % ROWS) * COLS + c] ==
					grid_next[r * COLS + ((c + COLS - 1) % COLS)]))) begin
					plaq_ok = 1'b0;
				end
			end
		end
		for (int k = 0; k < NUM_LABELS; k++) begin
			v_even[k] = '0;
			v_odd[k]  = '0;
			h_even[k] = '0;
			h_odd[k]  = '0;
		end
		for (int r = 0; r < ROWS; r++) begin
			ch = mod_colors(4'(grid_next[r * COLS]) +
				4'(grid_next[((r + ROWS - 1) % ROWS) * COLS]));
			for (int k = 0; k < NUM_LABELS; k++) begin
				if (4'(ch) == 4'(k)) begin
					if (r % 2 == 0) begin
						v_even[k][r] = 1'b1;
					end else begin
						v_odd[k][r] = 1'b1;
					end
				end
			end
		end
		for (int c = 0; c < COLS; c++) begin
			ch = mod_colors(4'(grid_next[c]) + 4'(grid_next[(c + COLS - 1) % COLS]));
			for (int k = 0; k < NUM_LABELS; k++) begin
				if (4'(ch) == 4'(k)) begin
					if (c % 2 == 0) begin
						h_even[k][c] = 1'b1;
					end else begin
						h_odd[k][c] = 1'b1;
					end
				end
			end
		end
		for (int k = 0; k < NUM_LABELS; k++) begin
			vsum = VW'(ROWS / 2) + VW'($countones(v_even[k])) - VW'($countones(v_odd[k]));
			hsum = HW'(COLS / 2) + HW'($countones(h_even[k])) - HW'($countones(h_odd[k]));
			vlabel[k] = vsum[LABEL_W-1:0];
			hlabel[k] = hsum[LABEL_W-1:0];
		end
	end

`ifndef ASSERT_OFF
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && flip_any |-> item_s1.func == FUNC_FLIP)
		else $error("flip reported for a write transaction");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance && flip_any |-> cell_new != cell_old)
		else $error("flip reported without a color change");

	assert property (@(posedge clk) disable iff (!arst_n)
		!items.ready |-> valid_s1 && valid_s2 && !results.ready)
		else $error("input stalled while the result stage can move");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("advanced transaction did not reach the result stage");
`endif

endmodule

// ===== sim/lattice_plaquette_flip_update_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lattice_plaquette_flip_update_core_tb
// Drives write and flip transactions into the plaquette flip update core
// and checks every result against a cycle-free model of the toroidal grid:
// flip flag, cell color, plaquette validity and the six symmetry labels.
// Stimulus is a short directed set followed by a random mix of neighbor
// setups, checkerboard fills and free transactions. Both sides idle at
// random, and one long receiver hold-off backs the core up.
// ----------------------------------------------------------------------------
module lattice_plaquette_flip_update_core_tb;
	import lpf_pkg::*;

	localparam int ROWS      = ROWS_DEF;
	localparam int COLS      = COLS_DEF;
	localparam int COLORS    = COLORS_DEF;
	localparam int HOLD_LEN  = 400;
	localparam int MAX_SHOWN = 10;
	localparam int ITEM_GOAL = 2000;

	logic clk;
	logic arst_n;

	lpf_item_if   item_ch();
	lpf_result_if result_ch();

	lattice_plaquette_flip_update_core #(
		.ROWS   (ROWS),
		.COLS   (COLS),
		.COLORS (COLORS)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (item_ch),
		.results (result_ch)
	);

	logic [COLOR_W-1:0] spin_model [ROWS][COLS];
	lpf_result_t        pending_results[$];
	int                 error_count = 0;
	int                 sent_count  = 0;
	bit                 steady_phase = 1'b0;
	int                 hold_request = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic lpf_result_t compute_plaquette_step(input lpf_item_t it);
		lpf_result_t        res;
		int                 r, c, rr, cc, prior_color, nxt, charge;
		logic [COLOR_W-1:0] right_color;
		int                 vert [NUM_LABELS];
		int                 horiz [NUM_LABELS];
		r   = int'(it.cell_row) % ROWS;
		c   = int'(it.cell_col) % COLS;
		res = '0;
		if (it.func == FUNC_WRITE) begin
			spin_model[r][c] = COLOR_W'(int'(it.spin_color) % COLORS);
		end else begin
			right_color = spin_model[r][(c + 1) % COLS];
			if (spin_model[(r + 1) % ROWS][c] == right_color &&
			    spin_model[r][(c + COLS - 1) % COLS] == right_color &&
			    spin_model[(r + ROWS - 1) % ROWS][c] == right_color) begin
				prior_color = int'(spin_model[r][c]);
				nxt = (prior_color + int'(it.color_step)) % COLORS;
				spin_model[r][c] = COLOR_W'(nxt);
				res.was_flipped = (nxt != prior_color);
			end
		end
		res.cell_color = spin_model[r][c];
		res.grid_valid = 1'b1;
		for (rr = 0; rr < ROWS; rr++) begin
			for (cc = 0; cc < COLS; cc++) begin
				if (!(spin_model[rr][cc] ==
				      spin_model[(rr + ROWS - 1) % ROWS][(cc + COLS - 1) % COLS] ||
				      spin_model[(rr + ROWS - 1) % ROWS][cc] ==
				      spin_model[rr][(cc + COLS - 1) % COLS]))
					res.grid_valid = 1'b0;
			end
		end
		for (int k = 0; k < NUM_LABELS; k++) begin
			vert[k]  = ROWS / 2;
			horiz[k] = COLS / 2;
			for (rr = 0; rr < ROWS; rr++) begin
				charge = (int'(spin_model[rr][0]) +
				          int'(spin_model[(rr + ROWS - 1) % ROWS][0])) % COLORS;
				if (charge == k)
					vert[k] += (rr % 2 == 1) ? -1 : 1;
			end
			for (cc = 0; cc < COLS; cc++) begin
				charge = (int'(spin_model[0][cc]) +
				          int'(spin_model[0][(cc + COLS - 1) % COLS])) % COLORS;
				if (charge == k)
					horiz[k] += (cc % 2 == 1) ? -1 : 1;
			end
		end
		res.vertical_label_0   = LABEL_W'(vert[0]);
		res.vertical_label_1   = LABEL_W'(vert[1]);
		res.vertical_label_2   = LABEL_W'(vert[2]);
		res.horizontal_label_0 = LABEL_W'(horiz[0]);
		res.horizontal_label_1 = LABEL_W'(horiz[1]);
		res.horizontal_label_2 = LABEL_W'(horiz[2]);
		return res;
	endfunction

	function automatic lpf_item_t make_item(input logic [FUNC_W-1:0] func,
	                                        input int row, input int col,
	                                        input int color, input int step);
		lpf_item_t it;
		it.func       = func;
		it.cell_row   = ROW_W'(row);
		it.cell_col   = COL_W'(col);
		it.spin_color = COLOR_W'(color);
		it.color_step = STEP_W'(step);
		return it;
	endfunction

	function automatic lpf_item_t random_item();
		return make_item(FUNC_W'($urandom_range(1)), $urandom_range(7), $urandom_range(3),
		                 $urandom_range(3), $urandom_range(3));
	endfunction

	// alias a row onto its wrapped code where the field allows it
	function automatic int row_code(input int r);
		if (r + ROWS < (1 << ROW_W) && $urandom_range(1) == 1)
			return r + ROWS;
		return r;
	endfunction

	// alias a color onto its out-of-range code where the field allows it
	function automatic int color_code(input int x);
		if (x + COLORS < (1 << COLOR_W) && $urandom_range(1) == 1)
			return x + COLORS;
		return x;
	endfunction

	task automatic send_item(input lpf_item_t it);
		lpf_result_t expected;
		if (!steady_phase) begin
			while ($urandom_range(99) < 34) begin
				item_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= it;
		do @(posedge clk); while (!item_ch.ready);
		expected = compute_plaquette_step(it);
		pending_results = {pending_results, expected};
		sent_count++;
	endtask

	task automatic send_random_sequence();
		int pick, r, c, x, a, b;
		pick = $urandom_range(99);
		if (pick < 30) begin
			r = $urandom_range(ROWS - 1);
			c = $urandom_range(COLS - 1);
			x = $urandom_range(COLORS - 1);
			send_item(make_item(FUNC_WRITE, row_code(r), (c + 1) % COLS, color_code(x), 0));
			send_item(make_item(FUNC_WRITE, row_code((r + 1) % ROWS), c, color_code(x), 0));
			send_item(make_item(FUNC_WRITE, row_code(r), (c + COLS - 1) % COLS,
			                    color_code(x), 0));
			// break the setup now and then
			if ($urandom_range(3) == 0)
				x = (x + 1) % COLORS;
			send_item(make_item(FUNC_WRITE, row_code((r + ROWS - 1) % ROWS), c,
			                    color_code(x), $urandom_range(3)));
			send_item(make_item(FUNC_FLIP, row_code(r), c, $urandom_range(3),
			                    $urandom_range(3)));
		end else if (pick < 45) begin
			a = $urandom_range(COLORS - 1);
			b = $urandom_range(COLORS - 1);
			for (r = 0; r < ROWS; r++) begin
				for (c = 0; c < COLS; c++) begin
					send_item(make_item(FUNC_WRITE, row_code(r), c,
					                    color_code(((r + c) % 2 == 1) ? b : a),
					                    $urandom_range(3)));
				end
			end
			if ($urandom_range(9) < 3)
				send_item(make_item(FUNC_WRITE, $urandom_range(7), $urandom_range(3),
				                    $urandom_range(3), $urandom_range(3)));
			repeat (4)
				send_item(make_item(FUNC_FLIP, $urandom_range(7), $urandom_range(3),
				                    $urandom_range(3), $urandom_range(3)));
		end else if (pick < 80) begin
			send_item(make_item(FUNC_FLIP, $urandom_range(7), $urandom_range(3),
			                    $urandom_range(3), $urandom_range(3)));
		end else begin
			send_item(random_item());
		end
	endtask

	task automatic test_reset_grid();
		send_item(make_item(FUNC_FLIP, 0, 0, 0, 1));
		send_item(make_item(FUNC_WRITE, 0, 0, 3, 0));
		send_item(make_item(FUNC_FLIP, 2, 2, 3, 1));
	endtask

	task automatic test_wrap_and_step();
		send_item(make_item(FUNC_FLIP, 5, 3, 0, 0));
		send_item(make_item(FUNC_FLIP, 5, 3, 0, 3));
		send_item(make_item(FUNC_FLIP, 7, 3, 0, 2));
		send_item(make_item(FUNC_WRITE, 6, 2, 2, 3));
		send_item(make_item(FUNC_FLIP, 1, 2, 1, 1));
		send_item(make_item(FUNC_WRITE, 7, 1, 1, 2));
		send_item(make_item(FUNC_FLIP, 3, 1, 2, 2));
	endtask

	task automatic test_labels_and_valid();
		send_item(make_item(FUNC_WRITE, 0, 0, 1, 0));
		send_item(make_item(FUNC_WRITE, 1, 0, 2, 0));
		send_item(make_item(FUNC_WRITE, 2, 0, 1, 0));
		send_item(make_item(FUNC_WRITE, 3, 0, 0, 0));
		send_item(make_item(FUNC_WRITE, 4, 0, 2, 0));
		send_item(make_item(FUNC_WRITE, 5, 0, 2, 0));
		send_item(make_item(FUNC_WRITE, 0, 1, 2, 0));
		send_item(make_item(FUNC_WRITE, 0, 2, 2, 0));
		send_item(make_item(FUNC_WRITE, 0, 3, 1, 0));
		send_item(make_item(FUNC_FLIP, 4, 3, 3, 1));
		send_item(make_item(FUNC_FLIP, 7, 3, 3, 3));
		send_item(make_item(FUNC_FLIP, 0, 1, 0, 2));
	endtask

	task automatic test_backpressure();
		hold_request++;
		repeat (40)
			send_item(random_item());
	endtask

	task automatic test_steady_stream();
		int stop_at;
		stop_at = sent_count + 300;
		steady_phase = 1'b1;
		while (sent_count < stop_at)
			send_random_sequence();
		steady_phase = 1'b0;
	endtask

	task automatic test_random_mix();
		while (sent_count < ITEM_GOAL)
			send_random_sequence();
	endtask

	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != hold_seen) begin
				hold_seen = hold_request;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= steady_phase || ($urandom_range(99) >= 34);
			end
		end
	end

	always @(posedge clk) begin
		lpf_result_t want;
		lpf_result_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = result_ch.data;
			if (pending_results.size() == 0) begin
				error_count++;
				if (error_count <= MAX_SHOWN)
					$display("unexpected result transaction: %p", got);
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				if (got.was_flipped        !== want.was_flipped        ||
				    got.cell_color         !== want.cell_color         ||
				    got.grid_valid         !== want.grid_valid         ||
				    got.vertical_label_0   !== want.vertical_label_0   ||
				    got.vertical_label_1   !== want.vertical_label_1   ||
				    got.vertical_label_2   !== want.vertical_label_2   ||
				    got.horizontal_label_0 !== want.horizontal_label_0 ||
				    got.horizontal_label_1 !== want.horizontal_label_1 ||
				    got.horizontal_label_2 !== want.horizontal_label_2) begin
					error_count++;
					if (error_count <= MAX_SHOWN)
						$display("result mismatch: expected %p, actual %p", want, got);
				end
			end
		end
	end

	initial begin
		for (int r = 0; r < ROWS; r++)
			for (int c = 0; c < COLS; c++)
				spin_model[r][c] = '0;
		arst_n        <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.data  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_grid();
		test_wrap_and_step();
		test_labels_and_valid();
		test_backpressure();
		test_steady_stream();
		test_random_mix();
		item_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/lpf_pkg.sv
rtl/core/lpf_if.sv
rtl/core/lattice_plaquette_flip_update_core.sv
sim/lattice_plaquette_flip_update_core_tb.sv
